// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the block pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define FBFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must never be seen at a clock edge outside reset.
`define FBFL_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FBFL_ASSERT(lbl, prop, msg)
`define FBFL_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/fbfl_pkg.sv =====
// Shared constants, types and helper functions of the block pool allocator.
package fbfl_pkg;

    // Pool geometry.
    localparam int MAX_BLOCKS      = 1024;
    localparam int ALIGN_BYTES     = 16;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int MAX_BLOCK_BYTES = 4096;

    // Field and storage widths.
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = IDX_W + 1;
    localparam int CNT_W      = 11;
    localparam int BYTES_W    = 13;
    localparam int TOTAL_W    = 11;
    localparam int OFF_W      = 22;
    localparam int END_W      = OFF_W + 1;
    localparam int DSH_W      = BYTES_W + IDX_W - 1;
    localparam int STEP_W     = $clog2(IDX_W);
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // The link value that ends the free list.
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISALIGN = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOTAL = 2'd1;

    // Link memory access from the controller.
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } mem_req_t;

    // Divider start request.
    typedef struct packed {
        logic               start;
        logic [OFF_W-1:0]   dividend;
        logic [BYTES_W-1:0] divisor;
    } div_req_t;

    // Divider result, valid while done is high.
    typedef struct packed {
        logic               done;
        logic [IDX_W-1:0]   quot;
        logic [BYTES_W-1:0] rem;
    } div_rsp_t;

    // Clamp the requested block size and round it up to the alignment.
    function automatic logic [BYTES_W-1:0] round_size(input logic [BYTES_W-1:0] raw);
        logic [BYTES_W-1:0] s;
        s = raw;
        if (s < BYTES_W'(MIN_BLOCK_BYTES)) s = BYTES_W'(MIN_BLOCK_BYTES);
        if (s > BYTES_W'(MAX_BLOCK_BYTES)) s = BYTES_W'(MAX_BLOCK_BYTES);
        // The alignment is a power of two, so rounding up is an add and a mask.
        return (s + BYTES_W'(ALIGN_BYTES - 1)) & ~BYTES_W'(ALIGN_BYTES - 1);
    endfunction

    // Clamp the requested block count to one through the pool capacity.
    function automatic logic [TOTAL_W-1:0] clamp_total(input logic [TOTAL_W-1:0] raw);
        logic [TOTAL_W-1:0] t;
        t = raw;
        if (t == '0) t = TOTAL_W'(1);
        if (t > TOTAL_W'(MAX_BLOCKS)) t = TOTAL_W'(MAX_BLOCKS);
        return t;
    endfunction

endpackage

// ===== rtl/fbfl_link_mem.sv =====
// Next-link memory of the free list: one write port and one registered read port.
module fbfl_link_mem (
    input  logic                             clk,
    input  fbfl_pkg::mem_req_t               req,
    output logic [fbfl_pkg::LINK_W-1:0]      rd_data
);

    logic [fbfl_pkg::LINK_W-1:0] mem [fbfl_pkg::MAX_BLOCKS];

    // Write and read in one clocked block; read data is registered and appears in the next cycle.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== rtl/fbfl_div.sv =====
// Iterative restoring divider that turns a byte offset into a block index and remainder.
module fbfl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fbfl_pkg::div_req_t req,
    output fbfl_pkg::div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [fbfl_pkg::STEP_W-1:0]    step_reg;
    logic [fbfl_pkg::STEP_W-1:0]    step_next;
    logic [fbfl_pkg::OFF_W-1:0]     rem_reg;
    logic [fbfl_pkg::OFF_W-1:0]     rem_next;
    logic [fbfl_pkg::DSH_W-1:0]     dsh_reg;
    logic [fbfl_pkg::DSH_W-1:0]     dsh_next;
    logic [fbfl_pkg::IDX_W-1:0]     quot_reg;
    logic [fbfl_pkg::IDX_W-1:0]     quot_next;
    logic                           fits;

    // The dividend is below divisor times the pool capacity, so one quotient
    // bit per cycle over the index width is enough.
    assign fits = (rem_reg >= fbfl_pkg::OFF_W'(dsh_reg));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = fbfl_pkg::STEP_W'(fbfl_pkg::IDX_W - 1);
            rem_next  = req.dividend;
            dsh_next  = fbfl_pkg::DSH_W'(req.divisor) << (fbfl_pkg::IDX_W - 1);
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - fbfl_pkg::OFF_W'(dsh_reg);
            end
            quot_next = {quot_reg[fbfl_pkg::IDX_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg[fbfl_pkg::BYTES_W-1:0];

endmodule

// ===== rtl/fbfl_ctrl.sv =====
// Command sequencer: list head, used count, link memory sweeps and the result register.
module fbfl_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fbfl_pkg::CMD_W-1:0]         cmd,
    input  logic [fbfl_pkg::OFF_W-1:0]         free_offset,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fbfl_pkg::STATUS_W-1:0]      status,
    output logic [fbfl_pkg::OFF_W-1:0]         block_offset,
    output logic [fbfl_pkg::IDX_W-1:0]         block_index,
    output logic [fbfl_pkg::CNT_W-1:0]         blocks_used,
    output logic [fbfl_pkg::CNT_W-1:0]         blocks_free,
    input  logic [fbfl_pkg::BYTES_W-1:0]       cfg_block_bytes,
    input  logic [fbfl_pkg::TOTAL_W-1:0]       cfg_block_total,
    output fbfl_pkg::mem_req_t                 mem_req,
    input  logic [fbfl_pkg::LINK_W-1:0]        mem_rd_data,
    output fbfl_pkg::div_req_t                 div_req,
    input  fbfl_pkg::div_rsp_t                 div_rsp
);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [fbfl_pkg::IDX_W-1:0]      clr_cnt_reg;
    logic [fbfl_pkg::IDX_W-1:0]      clr_cnt_next;
    logic                            clr_reply_reg;
    logic                            clr_reply_next;
    logic [fbfl_pkg::BYTES_W-1:0]    act_bytes_reg;
    logic [fbfl_pkg::BYTES_W-1:0]    act_bytes_next;
    logic [fbfl_pkg::TOTAL_W-1:0]    act_total_reg;
    logic [fbfl_pkg::TOTAL_W-1:0]    act_total_next;
    logic [fbfl_pkg::LINK_W-1:0]     head_reg;
    logic [fbfl_pkg::LINK_W-1:0]     head_next;
    logic [fbfl_pkg::CNT_W-1:0]      used_reg;
    logic [fbfl_pkg::CNT_W-1:0]      used_next;
    logic [fbfl_pkg::END_W-1:0]      end_reg;
    logic [fbfl_pkg::STATUS_W-1:0]   res_status_reg;
    logic [fbfl_pkg::STATUS_W-1:0]   res_status_next;
    logic [fbfl_pkg::OFF_W-1:0]      res_off_reg;
    logic [fbfl_pkg::OFF_W-1:0]      res_off_next;
    logic [fbfl_pkg::IDX_W-1:0]      res_idx_reg;
    logic [fbfl_pkg::IDX_W-1:0]      res_idx_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [fbfl_pkg::STATUS_W-1:0]   out_status_reg;
    logic [fbfl_pkg::OFF_W-1:0]      out_off_reg;
    logic [fbfl_pkg::IDX_W-1:0]      out_idx_reg;
    logic [fbfl_pkg::CNT_W-1:0]      out_used_reg;
    logic [fbfl_pkg::CNT_W-1:0]      out_free_reg;
    logic                            out_load;
    logic [fbfl_pkg::END_W-1:0]      alloc_prod;
    logic [fbfl_pkg::TOTAL_W-1:0]    new_total;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign alloc_prod = res_idx_reg * act_bytes_reg;
    assign new_total  = fbfl_pkg::clamp_total(cfg_block_total);

    // Command sequencing.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        act_bytes_next  = act_bytes_reg;
        act_total_next  = act_total_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_idx_next    = res_idx_reg;
        mem_req         = '0;
        div_req         = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                // Restore every link to point at the block below it; block zero ends the list.
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_cnt_reg;
                mem_req.wr_data = (clr_cnt_reg == '0) ? fbfl_pkg::NULL_LINK
                                : fbfl_pkg::LINK_W'(clr_cnt_reg) - 1'b1;
                if (clr_cnt_reg == fbfl_pkg::IDX_W'(fbfl_pkg::MAX_BLOCKS - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_reply_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = fbfl_pkg::ST_OK;
                    res_off_next    = '0;
                    res_idx_next    = '0;
                    state_next      = S_DONE;
                    unique case (cmd)
                        fbfl_pkg::CMD_ALLOC:
                        begin
                            if (head_reg >= fbfl_pkg::LINK_W'(act_total_reg))
                            begin
                                res_status_next = fbfl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = head_reg[fbfl_pkg::IDX_W-1:0];
                                res_idx_next    = head_reg[fbfl_pkg::IDX_W-1:0];
                                state_next      = S_ALLOC;
                            end
                        end
                        fbfl_pkg::CMD_FREE:
                        begin
                            if (fbfl_pkg::END_W'(free_offset) >= end_reg)
                            begin
                                res_status_next = fbfl_pkg::ST_RANGE;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = free_offset;
                                div_req.divisor  = act_bytes_reg;
                                state_next       = S_DIV;
                            end
                        end
                        fbfl_pkg::CMD_RESET:
                        begin
                            act_bytes_next = fbfl_pkg::round_size(cfg_block_bytes);
                            act_total_next = new_total;
                            head_next      = fbfl_pkg::LINK_W'(new_total) - 1'b1;
                            used_next      = '0;
                            clr_cnt_next   = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        default:
                        begin
                            // The unused command only reports the counts.
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                // Link data of the popped block is back from memory.
                head_next    = mem_rd_data;
                res_off_next = alloc_prod[fbfl_pkg::OFF_W-1:0];
                if (used_reg < fbfl_pkg::CNT_W'(act_total_reg))
                begin
                    used_next = used_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem != '0)
                    begin
                        res_status_next = fbfl_pkg::ST_MISALIGN;
                    end
                    else
                    begin
                        // Push the freed block on the list.
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = div_rsp.quot;
                        mem_req.wr_data = head_reg;
                        head_next       = fbfl_pkg::LINK_W'(div_rsp.quot);
                        res_idx_next    = div_rsp.quot;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    clr_reply_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat hand-off.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state; a hardware reset starts with a sweep of the link memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            act_bytes_reg <= fbfl_pkg::BYTES_W'(fbfl_pkg::MIN_BLOCK_BYTES);
            act_total_reg <= fbfl_pkg::TOTAL_W'(fbfl_pkg::MAX_BLOCKS);
            head_reg      <= fbfl_pkg::LINK_W'(fbfl_pkg::MAX_BLOCKS - 1);
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            act_bytes_reg <= act_bytes_next;
            act_total_reg <= act_total_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload and the pool end; the end settles during the memory sweep.
    always_ff @(posedge clk)
    begin
        end_reg        <= act_bytes_reg * act_total_reg;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_idx_reg    <= res_idx_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
            out_idx_reg    <= res_idx_reg;
            out_used_reg   <= used_reg;
            out_free_reg   <= (used_reg >= fbfl_pkg::CNT_W'(act_total_reg)) ? '0
                            : fbfl_pkg::CNT_W'(act_total_reg) - used_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign block_offset = out_off_reg;
    assign block_index  = out_idx_reg;
    assign blocks_used  = out_used_reg;
    assign blocks_free  = out_free_reg;

endmodule

// ===== rtl/fixed_block_free_list_allocator_top.sv =====
// Top level of the fixed-size block pool allocator with a LIFO free list.
//
//  Channel   Signals                                        Direction
//  in        in_valid, in_ready, cmd, free_offset           into the block
//  out       out_valid, out_ready, status, block_offset,    out of the block
//            block_index, blocks_used, blocks_free
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data      into the block
//
// An allocate steps through accept, one link memory read and the result load.
// A free waits on the divider, one quotient bit per cycle over 10 quotient bits;
// an out-of-range free and an empty-pool allocate go from accept to the result load.
// A pool reset command sweeps all 1024 links through the single memory write port before
// its result; after rst_n the same sweep runs before in_ready.
// One command is in work at a time; the next beat is accepted while a result waits in the
// output register, and a stalled output only holds the sequencer in its final state.
`include "assert_macros.svh"

module fixed_block_free_list_allocator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fbfl_pkg::CMD_W-1:0]         cmd,
    input  logic [fbfl_pkg::OFF_W-1:0]         free_offset,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fbfl_pkg::STATUS_W-1:0]      status,
    output logic [fbfl_pkg::OFF_W-1:0]         block_offset,
    output logic [fbfl_pkg::IDX_W-1:0]         block_index,
    output logic [fbfl_pkg::CNT_W-1:0]         blocks_used,
    output logic [fbfl_pkg::CNT_W-1:0]         blocks_free,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [fbfl_pkg::BYTES_W-1:0]   cfg_bytes_reg;
    logic [fbfl_pkg::BYTES_W-1:0]   cfg_bytes_next;
    logic [fbfl_pkg::TOTAL_W-1:0]   cfg_total_reg;
    logic [fbfl_pkg::TOTAL_W-1:0]   cfg_total_next;
    fbfl_pkg::mem_req_t             mem_req;
    logic [fbfl_pkg::LINK_W-1:0]    mem_rd_data;
    fbfl_pkg::div_req_t             div_req;
    fbfl_pkg::div_rsp_t             div_rsp;

    // Configuration writes are always taken; they apply at the next pool reset.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_bytes_next = cfg_bytes_reg;
        cfg_total_next = cfg_total_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fbfl_pkg::CFG_BLOCK_BYTES: cfg_bytes_next = cfg_data[fbfl_pkg::BYTES_W-1:0];
                fbfl_pkg::CFG_BLOCK_TOTAL: cfg_total_next = cfg_data[fbfl_pkg::TOTAL_W-1:0];
                default:                   cfg_bytes_next = cfg_bytes_reg;
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bytes_reg <= fbfl_pkg::BYTES_W'(fbfl_pkg::MIN_BLOCK_BYTES);
            cfg_total_reg <= fbfl_pkg::TOTAL_W'(fbfl_pkg::MAX_BLOCKS);
        end
        else
        begin
            cfg_bytes_reg <= cfg_bytes_next;
            cfg_total_reg <= cfg_total_next;
        end
    end

    // Command sequencer.
    fbfl_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .free_offset     (free_offset),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .block_offset    (block_offset),
        .block_index     (block_index),
        .blocks_used     (blocks_used),
        .blocks_free     (blocks_free),
        .cfg_block_bytes (cfg_bytes_reg),
        .cfg_block_total (cfg_total_reg),
        .mem_req         (mem_req),
        .mem_rd_data     (mem_rd_data),
        .div_req         (div_req),
        .div_rsp         (div_rsp)
    );

    // Next-link storage.
    fbfl_link_mem u_link_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // Offset to index divider.
    fbfl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Only one command is in work at a time.
    `FBFL_ASSERT(a_one_in_work, (in_valid && in_ready) |=> !in_ready, "beat accepted while busy")
    // The reported counts never exceed the pool capacity together.
    `FBFL_ASSERT(a_count_sum, out_valid |-> (blocks_used + blocks_free <= fbfl_pkg::MAX_BLOCKS), "counts over capacity")
    // A failed command reports no block.
    `FBFL_ASSERT_NEVER(a_err_no_block, out_valid && (status != fbfl_pkg::ST_OK) && ((block_index != '0) || (block_offset != '0)), "error result carries a block")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the fixed-size block pool allocator with a LIFO free list.
module tb_top;
    import fbfl_pkg::*;

    // The unused command code and the register indexes that the block ignores.
    localparam logic [CMD_W-1:0]     CMD_NOP     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int QUIET_LIMIT = 6000;
    localparam int END_SETTLE  = 40;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic [OFF_W-1:0] offset;
    } pool_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    offset;
        logic [IDX_W-1:0]    blk_index;
        logic [CNT_W-1:0]    used;
        logic [CNT_W-1:0]    avail;
    } pool_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CMD_W-1:0] cmd = CMD_ALLOC;
    logic [OFF_W-1:0] free_offset = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0] block_offset;
    logic [IDX_W-1:0] block_index;
    logic [CNT_W-1:0] blocks_used;
    logic [CNT_W-1:0] blocks_free;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Commands waiting to be driven and results waiting to come out.
    pool_cmd_t    cmd_queue[$];
    pool_result_t pending_results[$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int quiet_cycles = 0;

    // Shadow of the pool: registers, latched geometry, links, head and count.
    logic [BYTES_W-1:0] reg_bytes;
    logic [TOTAL_W-1:0] reg_total;
    int unsigned        live_bytes;
    int unsigned        live_total;
    logic [LINK_W-1:0]  link_mem[MAX_BLOCKS];
    logic [LINK_W-1:0]  head;
    logic [CNT_W-1:0]   used_cnt;
    // Blocks handed out and not yet returned, used to pick sensible frees.
    int unsigned        held_blocks[$];

    fixed_block_free_list_allocator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .free_offset  (free_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .block_offset (block_offset),
        .block_index  (block_index),
        .blocks_used  (blocks_used),
        .blocks_free  (blocks_free),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Latch the registers and relink every block, highest index at the head.
    function automatic void rebuild_model();
        int unsigned t;
        int unsigned s;
        t = reg_total;
        if (t < 1) t = 1;
        if (t > MAX_BLOCKS) t = MAX_BLOCKS;
        s = reg_bytes;
        if (s < MIN_BLOCK_BYTES) s = MIN_BLOCK_BYTES;
        if (s > MAX_BLOCK_BYTES) s = MAX_BLOCK_BYTES;
        live_total = t;
        live_bytes = ((s + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        for (int i = 0; i < MAX_BLOCKS; i++)
            link_mem[i] = (i == 0) ? NULL_LINK : LINK_W'(i - 1);
        head = LINK_W'(live_total - 1);
        used_cnt = '0;
        held_blocks.delete();
    endfunction

    // Apply one command to the shadow pool and return the result it gives.
    function automatic pool_result_t pool_step(input pool_cmd_t c);
        pool_result_t r;
        int unsigned  idx;
        int unsigned  off;
        int unsigned  pool_end;
        bit           found;
        r = '0;
        off = c.offset;
        pool_end = live_bytes * live_total;
        case (c.op)
            CMD_ALLOC:
            begin
                if (head >= live_total)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    idx = head;
                    head = link_mem[idx];
                    if (used_cnt < live_total) used_cnt++;
                    r.blk_index = IDX_W'(idx);
                    r.offset = OFF_W'(idx * live_bytes);
                    held_blocks.push_back(idx);
                end
            end
            CMD_FREE:
            begin
                if (off >= pool_end)
                begin
                    r.status = ST_RANGE;
                end
                else if (off % live_bytes != 0)
                begin
                    r.status = ST_MISALIGN;
                end
                else
                begin
                    // A double free is accepted and simply pushed again.
                    idx = off / live_bytes;
                    link_mem[idx] = head;
                    head = LINK_W'(idx);
                    if (used_cnt > 0) used_cnt--;
                    r.blk_index = IDX_W'(idx);
                    found = 1'b0;
                    for (int i = 0; i < held_blocks.size() && !found; i++)
                    begin
                        if (held_blocks[i] == idx)
                        begin
                            held_blocks.delete(i);
                            found = 1'b1;
                        end
                    end
                end
            end
            CMD_RESET: rebuild_model();
            default: ;
        endcase
        r.used = used_cnt;
        r.avail = (used_cnt >= live_total) ? '0 : CNT_W'(live_total - used_cnt);
        return r;
    endfunction

    // Command driver: predicts each accepted beat and presents the next one.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        pool_cmd_t next_cmd;
        pool_cmd_t taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_ALLOC;
            free_offset <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken.op = cmd;
                taken.offset = free_offset;
                pending_results.push_back(pool_step(taken));
            end
            if (!in_valid || in_ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_cmd = cmd_queue.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_cmd.op;
                    free_offset <= next_cmd.offset;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
            err_count++;
        end
    endtask

    // Result monitor: compares each accepted beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        pool_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d, offset %0d, index %0d",
                             $time, status, block_offset, block_index);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("block_offset", want.offset, block_offset);
                    check_field("block_index", want.blk_index, block_index);
                    check_field("blocks_used", want.used, blocks_used);
                    check_field("blocks_free", want.avail, blocks_free);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run when no channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [OFF_W-1:0] off);
        pool_cmd_t c;
        c.op = op;
        c.offset = off;
        cmd_queue.push_back(c);
    endtask

    // Block until every queued command is taken and every result has come.
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // One register write beat; the shadow copy follows the accepted write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_BLOCK_BYTES) reg_bytes = val;
        else if (idx == CFG_BLOCK_TOTAL) reg_total = val[TOTAL_W-1:0];
    endtask

    // Random command, mostly allocates and frees of blocks that are really held.
    function automatic pool_cmd_t random_cmd();
        pool_cmd_t   c;
        int unsigned pick;
        int unsigned k;
        int unsigned pool_end;
        pool_end = live_bytes * live_total;
        pick = $urandom_range(99);
        c.op = CMD_ALLOC;
        c.offset = OFF_W'($urandom);
        if (pick < 45)
        begin
            c.op = CMD_ALLOC;
        end
        else if (pick < 78)
        begin
            c.op = CMD_FREE;
            if (held_blocks.size() != 0)
                k = held_blocks[$urandom_range(held_blocks.size() - 1)];
            else
                k = $urandom_range(live_total - 1);
            c.offset = OFF_W'(k * live_bytes);
        end
        else if (pick < 86)
        begin
            c.op = CMD_FREE;
            k = $urandom_range(live_total - 1);
            c.offset = OFF_W'(k * live_bytes + $urandom_range(live_bytes - 1, 1));
        end
        else if (pick < 93)
        begin
            c.op = CMD_FREE;
            if (pool_end <= (1 << OFF_W) - 1)
                c.offset = OFF_W'($urandom_range((1 << OFF_W) - 1, pool_end));
        end
        else if (pick < 98)
        begin
            c.op = $urandom_range(1) ? CMD_NOP : CMD_FREE;
        end
        else if (pick < 99)
        begin
            c.op = CMD_RESET;
        end
        else
        begin
            c.op = CMD_NOP;
        end
        return c;
    endfunction

    // One phase: new geometry, a pool reset to apply it, then random traffic.
    task automatic run_phase(input int k, input int n);
        logic [CFG_DATA_W-1:0] bytes_v;
        logic [CFG_DATA_W-1:0] total_v;
        wait_idle();
        case (k % 5)
            0: bytes_v = CFG_DATA_W'(MAX_BLOCK_BYTES);
            1: bytes_v = '1;
            2: bytes_v = CFG_DATA_W'(MIN_BLOCK_BYTES + 1);
            3: bytes_v = CFG_DATA_W'($urandom);
            default: bytes_v = CFG_DATA_W'($urandom_range(200, MIN_BLOCK_BYTES));
        endcase
        case (k % 4)
            0: total_v = CFG_DATA_W'($urandom_range(12, 2));
            1: total_v = CFG_DATA_W'(1);
            2: total_v = ((k / 4) % 2 == 0) ? CFG_DATA_W'(MAX_BLOCKS) : '1;
            default: total_v = CFG_DATA_W'($urandom_range(20, 0));
        endcase
        write_reg(CFG_BLOCK_BYTES, bytes_v);
        write_reg(CFG_BLOCK_TOTAL, total_v);
        if (k % 3 == 0)
            write_reg((k % 2 != 0) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
        queue_cmd(CMD_RESET, OFF_W'($urandom));
        wait_idle();
        repeat (n)
        begin
            while (cmd_queue.size() >= 2) @(negedge clk);
            cmd_queue.push_back(random_cmd());
        end
    endtask

    initial
    begin : stimulus
        reg_bytes = BYTES_W'(MIN_BLOCK_BYTES);
        reg_total = TOTAL_W'(MAX_BLOCKS);
        rebuild_model();
        send_gap_pct = 16;
        recv_stall_pct = 76;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry: top block, its return, an all-ones offset, a bad
        // alignment and the unused command.
        queue_cmd(CMD_ALLOC, '1);
        queue_cmd(CMD_FREE, OFF_W'((MAX_BLOCKS - 1) * MIN_BLOCK_BYTES));
        queue_cmd(CMD_FREE, '1);
        queue_cmd(CMD_FREE, OFF_W'(8));
        queue_cmd(CMD_NOP, '0);
        wait_idle();

        // Three blocks of the smallest size; spare indexes must be ignored.
        write_reg(CFG_BLOCK_BYTES, '0);
        write_reg(CFG_BLOCK_TOTAL, CFG_DATA_W'(3));
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        queue_cmd(CMD_RESET, '0);
        // Drain the pool, then one more allocate finds it empty.
        repeat (4) queue_cmd(CMD_ALLOC, '0);
        // Double free of block one makes it link to itself.
        queue_cmd(CMD_FREE, OFF_W'(16));
        queue_cmd(CMD_FREE, OFF_W'(16));
        // Allocates now keep returning the same block, the count rising to the capacity and then pinned.
        repeat (3) queue_cmd(CMD_ALLOC, '0);
        // Offset at the pool end, and one just short of it.
        queue_cmd(CMD_FREE, OFF_W'(48));
        queue_cmd(CMD_FREE, OFF_W'(47));
        // Repeated frees drive the used count down to zero and hold it.
        repeat (4) queue_cmd(CMD_FREE, '0);

        for (int k = 0; k < 15; k++)
        begin
            if (k == 5)
            begin
                send_gap_pct = 76;
                recv_stall_pct = 16;
            end
            if (k == 10)
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            run_phase(k, 60);
        end

        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
